[rtl/machine_check_register_bank_assert.svh]
// ----------------------------------------------------------------------------
// Machine-check register bank assertion macros
// Concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MACHINE_CHECK_REGISTER_BANK_ASSERT_SVH
`define MACHINE_CHECK_REGISTER_BANK_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MCRB_ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("machine check bank: implication failed");

// Next-cycle implication.
`define MCRB_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("machine check bank: next-cycle implication failed");

`else

`define MCRB_ASSERT_IMPL(name, clk, rst_n, pre, post)
`define MCRB_ASSERT_NEXT(name, clk, rst_n, pre, post)

`endif

`endif

[rtl/mcrb_pkg.sv]
// ----------------------------------------------------------------------------
// mcrb_pkg
// Codes, register numbers and decode types of the machine-check register bank.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrb_pkg;

    // request modes
    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_INJECT = 2'd2;

    // response status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_REG  = 2'd1;
    localparam logic [1:0] ST_BAD_STAT = 2'd2;
    localparam logic [1:0] ST_BAD_CPU  = 2'd3;

    // configuration register indexes
    localparam int          CFG_IDX_W       = 1;
    localparam int          CFG_DATA_W      = 8;
    localparam logic [0:0]  CFG_CTL_PRESENT = 1'd0;
    localparam logic [0:0]  CFG_BANK_COUNT  = 1'd1;

    // register numbers
    localparam logic [11:0] MSR_GLOBAL_CAP  = 12'h179;
    localparam logic [11:0] MSR_GLOBAL_STAT = 12'h17A;
    localparam logic [11:0] MSR_GLOBAL_CTRL = 12'h17B;
    localparam logic [11:0] BANK_BASE       = 12'h400;
    localparam logic [9:0]  BANK_BASE_QUAD  = BANK_BASE[11:2];

    // register within a bank
    localparam logic [1:0] BREG_CTL  = 2'd0;
    localparam logic [1:0] BREG_STAT = 2'd1;
    localparam logic [1:0] BREG_ADDR = 2'd2;
    localparam logic [1:0] BREG_MISC = 2'd3;

    localparam logic [5:0] CTRL_BITS   = 6'h3f;
    localparam int         GCTL_NB_BIT = 4;
    localparam int         NB_BANK     = 4;
    localparam logic [2:0] STAT_RIPV   = 3'b001;
    localparam logic [2:0] STAT_MCIP   = 3'b100;

    typedef struct packed {
        logic       is_cap;
        logic       is_gstat;
        logic       is_gctl;
        logic       is_bank;
        logic [1:0] reg_sel;
        logic [9:0] bank_num;
    } mcrb_dec_t;

endpackage

`default_nettype wire

[rtl/mcrb_if.sv]
// ----------------------------------------------------------------------------
// mcrb channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcrb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] msr_index;
    logic [63:0] data;
    logic [63:0] inject_addr;
    logic [7:0]  cpu_index;

    modport source (
        output valid, mode, msr_index, data, inject_addr, cpu_index,
        input  ready
    );
    modport sink (
        input  valid, mode, msr_index, data, inject_addr, cpu_index,
        output ready
    );
endinterface

interface mcrb_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic [1:0]  status;
    logic        raise_mce;

    modport source (
        output valid, read_data, status, raise_mce,
        input  ready
    );
    modport sink (
        input  valid, read_data, status, raise_mce,
        output ready
    );
endinterface

`default_nettype wire

[rtl/machine_check_register_bank.sv]
// ----------------------------------------------------------------------------
// machine_check_register_bank
// Machine-check global registers and error-reporting banks.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per handshake: a register read, a register
//   write or a northbridge error injection. rsp returns exactly one
//   response per request, in order: read data, status code, and a flag
//   that is set when a machine-check exception is raised.
//   cfg_we / cfg_index / cfg_data set the control-support flag (index 0)
//   and the reported bank count (index 1); write them only while idle.
// Timing:
//   A request is registered on acceptance, then decoded, executed and
//   committed as it moves into the response register. One request per
//   cycle is sustained while rsp is not held off, with a single
//   decode-and-update pass between the two registers.
// Reset:
//   Global registers and banks clear to zero; control support resets to 1
//   and the bank count to 6. Requests are accepted at once after reset.
// Stall:
//   With rsp held off, one more request is accepted into the input
//   register and then req.ready drops until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "machine_check_register_bank_assert.svh"

module machine_check_register_bank #(
    parameter int NUM_BANKS = 6
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    mcrb_req_if.sink                             req,
    mcrb_rsp_if.source                           rsp,
    input  wire logic                            cfg_we,
    input  wire logic [mcrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mcrb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mcrb_pkg::*;

    localparam int BIDX_W = $clog2(NUM_BANKS);

    // configuration
    logic       ctl_present_reg;
    logic [7:0] bank_count_reg;

    // architectural state
    logic [2:0]  gstat_reg;
    logic [5:0]  gctl_reg;
    logic [63:0] bctl_reg  [NUM_BANKS];
    logic [63:0] bstat_reg [NUM_BANKS];
    logic [63:0] baddr_reg [NUM_BANKS];

    // input stage
    logic        s1_vld_reg;
    logic [1:0]  s1_mode_reg;
    logic [11:0] s1_msr_reg;
    logic [63:0] s1_data_reg;
    logic [63:0] s1_iaddr_reg;
    logic [7:0]  s1_cpu_reg;

    // response stage
    logic        out_vld_reg;
    logic [63:0] out_rd_reg;
    logic [1:0]  out_st_reg;
    logic        out_raise_reg;

    logic out_free;
    logic s1_fire;
    logic in_fire;

    mcrb_dec_t         dec;
    logic [BIDX_W-1:0] bidx;
    logic              wr;

    logic [63:0] rd_next;
    logic [1:0]  st_next;
    logic        raise_next;
    logic        gstat_clr;
    logic        gctl_we;
    logic        bctl_we;
    logic        bstat_clr;
    logic        baddr_we;
    logic        inject_we;

    assign out_free  = !out_vld_reg || rsp.ready;
    assign s1_fire   = s1_vld_reg && out_free;
    assign req.ready = !s1_vld_reg || out_free;
    assign in_fire   = req.valid && req.ready;

    assign rsp.valid     = out_vld_reg;
    assign rsp.read_data = out_rd_reg;
    assign rsp.status    = out_st_reg;
    assign rsp.raise_mce = out_raise_reg;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_present_reg <= 1'b1;
            bank_count_reg  <= 8'd6;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CTL_PRESENT: ctl_present_reg <= cfg_data[0];
                CFG_BANK_COUNT:  bank_count_reg  <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_vld_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg  <= req.mode;
            s1_msr_reg   <= req.msr_index;
            s1_data_reg  <= req.data;
            s1_iaddr_reg <= req.inject_addr;
            s1_cpu_reg   <= req.cpu_index;
        end
    end

    // ------------------------------------------------------------------
    // decode and execute
    // ------------------------------------------------------------------
    mcrb_decode #(
        .NUM_BANKS (NUM_BANKS)
    ) u_decode (
        .msr_index (s1_msr_reg),
        .dec       (dec)
    );

    assign bidx = dec.bank_num[BIDX_W-1:0];
    assign wr   = (s1_mode_reg == MODE_WRITE);

    always_comb
    begin
        rd_next    = 64'd0;
        st_next    = ST_OK;
        raise_next = 1'b0;
        gstat_clr  = 1'b0;
        gctl_we    = 1'b0;
        bctl_we    = 1'b0;
        bstat_clr  = 1'b0;
        baddr_we   = 1'b0;
        inject_we  = 1'b0;
        case (s1_mode_reg)
            MODE_READ, MODE_WRITE:
            begin
                if (dec.is_cap)
                begin
                    if (!wr)
                        rd_next = {55'd0, ctl_present_reg, bank_count_reg};
                end
                else if (dec.is_gstat)
                begin
                    if (wr)
                        gstat_clr = 1'b1;
                    else
                        rd_next = {61'd0, gstat_reg};
                end
                else if (dec.is_gctl)
                begin
                    if (ctl_present_reg)
                    begin
                        if (wr)
                            gctl_we = 1'b1;
                        else
                            rd_next = {58'd0, gctl_reg};
                    end
                end
                else if (!dec.is_bank)
                begin
                    st_next = ST_BAD_REG;
                end
                else
                begin
                    case (dec.reg_sel)
                        BREG_CTL:
                        begin
                            if (ctl_present_reg)
                            begin
                                if (wr)
                                    bctl_we = 1'b1;
                                else
                                    rd_next = bctl_reg[bidx];
                            end
                        end
                        BREG_STAT:
                        begin
                            if (!wr)
                                rd_next = bstat_reg[bidx];
                            else if (s1_data_reg != 64'd0)
                                st_next = ST_BAD_STAT;
                            else
                                bstat_clr = 1'b1;
                        end
                        BREG_ADDR:
                        begin
                            if (wr)
                                baddr_we = 1'b1;
                            else
                                rd_next = baddr_reg[bidx];
                        end
                        default: ; // misc reads zero, writes drop
                    endcase
                end
            end
            MODE_INJECT:
            begin
                if (s1_cpu_reg != 8'd0)
                begin
                    st_next = ST_BAD_CPU;
                end
                else if (gctl_reg[GCTL_NB_BIT])
                begin
                    inject_we  = 1'b1;
                    raise_next = 1'b1;
                end
            end
            default: st_next = ST_BAD_REG;
        endcase
    end

    // ------------------------------------------------------------------
    // state update, committed as the request moves to the response
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gstat_reg <= 3'd0;
            gctl_reg  <= 6'd0;
            for (int i = 0; i < NUM_BANKS; i++)
            begin
                bctl_reg[i]  <= 64'd0;
                bstat_reg[i] <= 64'd0;
                baddr_reg[i] <= 64'd0;
            end
        end
        else if (s1_fire)
        begin
            if (gstat_clr)
                gstat_reg <= 3'd0;
            else if (inject_we)
                gstat_reg <= STAT_RIPV | STAT_MCIP;
            if (gctl_we)
                gctl_reg <= s1_data_reg[5:0] & CTRL_BITS;
            for (int i = 0; i < NUM_BANKS; i++)
            begin
                if (bctl_we && bidx == BIDX_W'(i))
                    bctl_reg[i] <= s1_data_reg;
                if (bstat_clr && bidx == BIDX_W'(i))
                    bstat_reg[i] <= 64'd0;
                else if (inject_we && i == NB_BANK)
                    bstat_reg[i] <= s1_data_reg;
                if (baddr_we && bidx == BIDX_W'(i))
                    baddr_reg[i] <= s1_data_reg;
                else if (inject_we && i == NB_BANK)
                    baddr_reg[i] <= s1_iaddr_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // response register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_rd_reg    <= rd_next;
            out_st_reg    <= st_next;
            out_raise_reg <= raise_next;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `MCRB_ASSERT_IMPL(a_raise_is_ok, clk, rst_n, out_vld_reg && out_raise_reg,
        out_st_reg == ST_OK)
    `MCRB_ASSERT_IMPL(a_data_only_ok, clk, rst_n, out_vld_reg && out_rd_reg != 64'd0,
        out_st_reg == ST_OK)
    `MCRB_ASSERT_NEXT(a_inject_sets_status, clk, rst_n, s1_fire && inject_we,
        gstat_reg == (STAT_RIPV | STAT_MCIP))
    `MCRB_ASSERT_IMPL(a_stall_only_full, clk, rst_n, !req.ready,
        s1_vld_reg && out_vld_reg && !rsp.ready)

endmodule

`default_nettype wire

[rtl/mcrb_decode.sv]
// ----------------------------------------------------------------------------
// mcrb_decode
// Classifies a register number as global register, bank register or unknown.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrb_decode #(
    parameter int NUM_BANKS = 6
) (
    input  wire logic [11:0]       msr_index,
    output mcrb_pkg::mcrb_dec_t    dec
);
    import mcrb_pkg::*;

    logic [9:0] quad;
    logic [9:0] bank_num;
    logic       above_base;

    assign quad       = msr_index[11:2];
    assign above_base = (msr_index[11:10] != 2'd0);
    assign bank_num   = quad - BANK_BASE_QUAD;

    always_comb
    begin
        dec.is_cap   = (msr_index == MSR_GLOBAL_CAP);
        dec.is_gstat = (msr_index == MSR_GLOBAL_STAT);
        dec.is_gctl  = (msr_index == MSR_GLOBAL_CTRL);
        dec.is_bank  = above_base && (bank_num < 10'(NUM_BANKS));
        dec.reg_sel  = msr_index[1:0];
        dec.bank_num = bank_num;
    end

endmodule

`default_nettype wire

[test/machine_check_register_bank_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// machine_check_register_bank_checker
// Watches the request, response and configuration ports of the register
// bank, keeps a shadow copy of its registers and banks, predicts the
// response of every accepted request and compares each response in order.
// ----------------------------------------------------------------------------
module machine_check_register_bank_checker #(
    parameter int NUM_BANKS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mcrb_req_if                             req,
    mcrb_rsp_if                             rsp,
    input  logic                            cfg_we,
    input  logic [mcrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcrb_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import mcrb_pkg::*;

    localparam logic [7:0] RESET_BANK_COUNT = 8'd6;

    typedef struct packed {
        logic [63:0] read_data;
        logic [1:0]  status;
        logic        raise_mce;
    } response_t;

    // shadow configuration and register state
    logic        ctl_present_q;
    logic [7:0]  bank_count_q;
    logic [2:0]  gstat_q;
    logic [5:0]  gctl_q;
    logic [63:0] bank_ctl  [NUM_BANKS];
    logic [63:0] bank_stat [NUM_BANKS];
    logic [63:0] bank_addr [NUM_BANKS];

    response_t expected_responses[$];
    response_t want;
    int        mismatches  = 0;
    int        outstanding = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_val);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    // bank number holding msr, or -1 when no bank does
    function automatic int bank_of(input logic [11:0] msr);
        logic [11:0] quad_base;
        int          n;
        quad_base = msr & 12'hffc;
        if (quad_base < BANK_BASE)
            return -1;
        n = int'((quad_base - BANK_BASE) >> 2);
        if (n >= NUM_BANKS)
            return -1;
        return n;
    endfunction

    // compute the response of one request and commit its side effects
    function automatic response_t predict_response(
        input logic [1:0]  mode,
        input logic [11:0] msr,
        input logic [63:0] data,
        input logic [63:0] iaddr,
        input logic [7:0]  cpu
    );
        response_t r;
        int        b;
        logic      wr;
        r  = '0;
        wr = (mode == MODE_WRITE);
        if (mode == MODE_READ || mode == MODE_WRITE)
        begin
            if (msr == MSR_GLOBAL_CAP)
            begin
                if (!wr)
                    r.read_data = {55'd0, ctl_present_q, bank_count_q};
            end
            else if (msr == MSR_GLOBAL_STAT)
            begin
                if (wr)
                    gstat_q = '0;
                else
                    r.read_data = {61'd0, gstat_q};
            end
            else if (msr == MSR_GLOBAL_CTRL)
            begin
                if (ctl_present_q)
                begin
                    if (wr)
                        gctl_q = data[5:0] & CTRL_BITS;
                    else
                        r.read_data = {58'd0, gctl_q};
                end
            end
            else
            begin
                b = bank_of(msr);
                if (b < 0)
                    r.status = ST_BAD_REG;
                else
                begin
                    case (msr[1:0])
                        BREG_CTL:
                        begin
                            if (ctl_present_q)
                            begin
                                if (wr)
                                    bank_ctl[b] = data;
                                else
                                    r.read_data = bank_ctl[b];
                            end
                        end
                        BREG_STAT:
                        begin
                            if (wr)
                            begin
                                if (data != '0)
                                    r.status = ST_BAD_STAT;
                                else
                                    bank_stat[b] = '0;
                            end
                            else
                                r.read_data = bank_stat[b];
                        end
                        BREG_ADDR:
                        begin
                            if (wr)
                                bank_addr[b] = data;
                            else
                                r.read_data = bank_addr[b];
                        end
                        default: ;
                    endcase
                end
            end
        end
        else if (mode == MODE_INJECT)
        begin
            if (cpu != '0)
                r.status = ST_BAD_CPU;
            else if (gctl_q[GCTL_NB_BIT])
            begin
                bank_stat[NB_BANK] = data;
                bank_addr[NB_BANK] = iaddr;
                gstat_q            = STAT_RIPV | STAT_MCIP;
                r.raise_mce        = 1'b1;
            end
        end
        else
            r.status = ST_BAD_REG;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_present_q = 1'b1;
            bank_count_q  = RESET_BANK_COUNT;
            gstat_q       = '0;
            gctl_q        = '0;
            for (int i = 0; i < NUM_BANKS; i++)
            begin
                bank_ctl[i]  = '0;
                bank_stat[i] = '0;
                bank_addr[i] = '0;
            end
            expected_responses.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CTL_PRESENT: ctl_present_q = cfg_data[0];
                    CFG_BANK_COUNT:  bank_count_q  = cfg_data;
                    default: ;
                endcase
            end

            // retire the response first so a stray one cannot match this cycle's request
            if (rsp.valid && rsp.ready)
            begin
                if (expected_responses.size() == 0)
                    report("response with no request waiting", rsp.read_data, '0);
                else
                begin
                    want = expected_responses.pop_front();
                    if (rsp.read_data !== want.read_data)
                        report("read_data", rsp.read_data, want.read_data);
                    if (rsp.status !== want.status)
                        report("status", 64'(rsp.status), 64'(want.status));
                    if (rsp.raise_mce !== want.raise_mce)
                        report("raise_mce", 64'(rsp.raise_mce), 64'(want.raise_mce));
                end
            end

            if (req.valid && req.ready)
                expected_responses.push_back(predict_response(req.mode, req.msr_index,
                                                              req.data, req.inject_addr,
                                                              req.cpu_index));

            outstanding = expected_responses.size();
        end
    end

endmodule

[test/machine_check_register_bank_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// machine_check_register_bank_test
// Drives register reads, writes and error injections into the register bank
// in random bursts, stalls the response side on a changing pattern, walks
// through several configurations and reports the checker's verdict.
// ----------------------------------------------------------------------------
module machine_check_register_bank_test;
    import mcrb_pkg::*;

    localparam int         NUM_BANKS    = 6;
    localparam int         PHASES       = 6;
    localparam int         RANDOM_ITEMS = 1650;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    burst_left;

    mcrb_req_if req ();
    mcrb_rsp_if rsp ();

    machine_check_register_bank #(
        .NUM_BANKS (NUM_BANKS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    machine_check_register_bank_checker #(
        .NUM_BANKS (NUM_BANKS)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int next_burst_len();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(30, 80);
        return $urandom_range(1, 12);
    endfunction

    function automatic logic [11:0] msr_of(input int bank, input logic [1:0] breg);
        return BANK_BASE + 12'(4 * bank) + 12'(breg);
    endfunction

    // hold one request until it is taken, then maybe idle for a gap
    task automatic send_request(
        input logic [1:0]  mode,
        input logic [11:0] msr,
        input logic [63:0] data,
        input logic [63:0] addr,
        input logic [7:0]  cpu
    );
        req.valid       <= 1'b1;
        req.mode        <= mode;
        req.msr_index   <= msr;
        req.data        <= data;
        req.inject_addr <= addr;
        req.cpu_index   <= cpu;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = next_burst_len();
        end
    endtask

    task automatic random_request();
        logic [1:0]  mode;
        logic [11:0] msr;
        logic [63:0] data;
        logic [7:0]  cpu;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            mode = MODE_READ;
        else if (pick < 75)
            mode = MODE_WRITE;
        else if (pick < 96)
            mode = MODE_INJECT;
        else
            mode = MODE_UNUSED;

        // mostly decoded registers, up to two banks past the end, some noise
        pick = $urandom_range(0, 99);
        if (pick < 15)
            msr = MSR_GLOBAL_CTRL;
        else if (pick < 22)
            msr = MSR_GLOBAL_STAT;
        else if (pick < 27)
            msr = MSR_GLOBAL_CAP;
        else if (pick < 85)
            msr = BANK_BASE + 12'($urandom_range(0, 4 * NUM_BANKS + 7));
        else
            msr = 12'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 30)
            data = '0;
        else if (pick < 35)
            data = '1;
        else
            data = {$urandom, $urandom};

        cpu = ($urandom_range(0, 3) != 0) ? 8'd0 : 8'($urandom_range(0, 255));
        send_request(mode, msr, data, {$urandom, $urandom}, cpu);
    endtask

    // drop valid and hold until every request has been answered
    task automatic wait_idle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // response side: pick a new stall style after each randomly sized run
    initial
    begin
        int style;
        int left;
        rsp.ready <= 1'b0;
        style = 0;
        left  = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                style = $urandom_range(0, 3);
                left  = $urandom_range(50, 300);
            end
            left--;
            case (style)
                0:       rsp.ready <= 1'b1;
                1:       rsp.ready <= ($urandom_range(0, 3) != 0);
                2:       rsp.ready <= ($urandom_range(0, 3) == 0);
                default: rsp.ready <= ((left % 7) < 2);
            endcase
        end
    end

    initial
    begin
        int phase;
        req.valid       <= 1'b0;
        req.mode        <= MODE_READ;
        req.msr_index   <= '0;
        req.data        <= '0;
        req.inject_addr <= '0;
        req.cpu_index   <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        burst_left = next_burst_len();
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // global registers straight out of reset
        send_request(MODE_READ,  MSR_GLOBAL_CAP,  '0, '0, 8'd0);
        send_request(MODE_READ,  MSR_GLOBAL_STAT, '0, '0, 8'd0);
        send_request(MODE_READ,  MSR_GLOBAL_CTRL, '0, '0, 8'd0);
        send_request(MODE_WRITE, MSR_GLOBAL_CTRL, '1, '0, 8'd0);
        send_request(MODE_READ,  MSR_GLOBAL_CTRL, '0, '0, 8'd0);
        // bank registers at both ends of the bank range
        send_request(MODE_WRITE, msr_of(0, BREG_CTL), '1, '0, 8'd0);
        send_request(MODE_READ,  msr_of(0, BREG_CTL), '0, '0, 8'd0);
        send_request(MODE_WRITE, msr_of(NUM_BANKS - 1, BREG_ADDR), '1, '0, 8'd0);
        send_request(MODE_READ,  msr_of(NUM_BANKS - 1, BREG_ADDR), '0, '0, 8'd0);
        send_request(MODE_WRITE, msr_of(2, BREG_STAT), '1, '0, 8'd0);
        send_request(MODE_WRITE, msr_of(2, BREG_STAT), '0, '0, 8'd0);
        send_request(MODE_READ,  msr_of(3, BREG_MISC), '0, '0, 8'd0);
        send_request(MODE_WRITE, msr_of(3, BREG_MISC), '1, '0, 8'd0);
        // unknown registers
        send_request(MODE_READ,  msr_of(NUM_BANKS, BREG_CTL), '0, '0, 8'd0);
        send_request(MODE_WRITE, msr_of(NUM_BANKS, BREG_STAT), '1, '0, 8'd0);
        send_request(MODE_READ,  12'hfff, '0, '0, 8'd0);
        send_request(MODE_WRITE, 12'h000, '1, '0, 8'd0);
        // injection with the northbridge bank enabled, then clear the status
        send_request(MODE_INJECT, '0, '1, '1, 8'd0);
        send_request(MODE_READ,   msr_of(NB_BANK, BREG_STAT), '0, '0, 8'd0);
        send_request(MODE_READ,   MSR_GLOBAL_STAT, '0, '0, 8'd0);
        send_request(MODE_WRITE,  MSR_GLOBAL_STAT, '1, '0, 8'd0);
        send_request(MODE_INJECT, '0, '1, '1, 8'hff);
        send_request(MODE_WRITE,  MSR_GLOBAL_CTRL, '0, '0, 8'd0);
        send_request(MODE_INJECT, '0, '1, '1, 8'd0);
        send_request(MODE_UNUSED, MSR_GLOBAL_CAP, '1, '1, 8'd0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    write_config(CFG_CTL_PRESENT, {7'($urandom), 1'b0});
                    write_config(CFG_BANK_COUNT, 8'd0);
                end
                1:
                begin
                    write_config(CFG_CTL_PRESENT, 8'd1);
                    write_config(CFG_BANK_COUNT, 8'hff);
                end
                2:
                begin
                    write_config(CFG_CTL_PRESENT, 8'd0);
                    write_config(CFG_BANK_COUNT, 8'($urandom));
                end
                3:
                begin
                    write_config(CFG_CTL_PRESENT, {7'($urandom), 1'b1});
                    write_config(CFG_BANK_COUNT, 8'($urandom));
                end
                4:
                begin
                    write_config(CFG_CTL_PRESENT, 8'($urandom));
                    write_config(CFG_BANK_COUNT, 8'd6);
                end
                default:
                begin
                    write_config(CFG_CTL_PRESENT, 8'd1);
                    write_config(CFG_BANK_COUNT, 8'($urandom));
                end
            endcase
            repeat (RANDOM_ITEMS / PHASES)
                random_request();
        end

        wait_idle();
        repeat (8)
            @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/mcrb_pkg.sv
rtl/mcrb_if.sv
rtl/mcrb_decode.sv
rtl/machine_check_register_bank.sv
test/machine_check_register_bank_checker.sv
test/machine_check_register_bank_test.sv
